### hw/rtl/rsc_pkg.sv
// Shared types, constants and kernel helpers for the RGB 3x3 sharpen filter.
// No dependencies. Used by rsc_column_cell and rgb_sharpen_convolution_3x3.
package rsc_pkg;

  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int OUT_COL_W   = 11;
  localparam int OUT_ROW_W   = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int FW_W        = 12;
  localparam int FH_W        = 13;
  localparam int KSEL_W      = 2;
  localparam int PSUM_W      = 13;
  localparam int WEIGHT_W    = 5;
  localparam int DIM_MIN     = 3;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int KERNEL_COUNT = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KERNEL_SELECT = 2'd0,
    CFG_FRAME_WIDTH   = 2'd1,
    CFG_FRAME_HEIGHT  = 2'd2
  } cfg_index_t;

  typedef logic [CHAN_W-1:0]          chan_t;
  typedef chan_t [2:0]                pixel_t;   // [0] red, [1] green, [2] blue
  typedef pixel_t [2:0]               column_t;  // [0] top row, [2] current row
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [2:0]              kcol_t;    // one kernel column, top to bottom
  typedef logic signed [PSUM_W-1:0]   psum_t;
  typedef psum_t [2:0]                psum_vec_t; // per channel

  localparam psum_t CLAMP_HI = 13'sd255;

  // cross, full, alternate; row-major
  localparam weight_t KERNELS [KERNEL_COUNT][9] = '{
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{ 5'sd1, -5'sd2,  5'sd1, -5'sd2,  5'sd5, -5'sd2,  5'sd1, -5'sd2,  5'sd1}
  };

  function automatic kcol_t kernel_column(input logic [KSEL_W-1:0] sel, input int col);
    kcol_t k;
    int    idx;
    idx = (int'(sel) < KERNEL_COUNT) ? int'(sel) : 0;
    for (int row = 0; row < 3; row++) begin
      k[row] = KERNELS[idx][row * 3 + col];
    end
    return k;
  endfunction

  function automatic psum_vec_t col_sum(input kcol_t k, input column_t c);
    psum_vec_t acc;
    acc = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int row = 0; row < 3; row++) begin
        acc[ch] = acc[ch] + PSUM_W'($signed(k[row]) * $signed({5'b0, c[row][ch]}));
      end
    end
    return acc;
  endfunction

endpackage

### hw/rtl/rsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/rsc_column_cell.sv
// One window column cell: holds three pixels of a column, shifts them on,
// and forms the weighted column sum per channel. Depends on rsc_pkg.
module rsc_column_cell
  import rsc_pkg::*;
(
  input  logic      clk,
  input  logic      shift,
  input  column_t   col_in,
  input  kcol_t     weights,
  output column_t   col_out,
  output psum_vec_t psum
);

  column_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= col_in;
    end
  end

  assign col_out = held;
  assign psum    = col_sum(weights, held);

endmodule

### hw/rtl/rgb_sharpen_convolution_3x3.sv
// Top level of the RGB 3x3 sharpen filter: counters, line stores, window cells,
// sum/clamp and result stage. Depends on rsc_pkg, rsc_ram, rsc_column_cell.
//
// Pixels enter in raster order at one per clock while pixel_stall is low. Each
// accepted pixel gives zero, one or two results; a pixel with two results
// (interior result for the pixel up-left of it, then its own border
// pass-through) holds the single output port for both in turn, so pixels of
// the last column from the third row on and of the last row from the third
// column on give two results and every other pixel at most one. Two line
// stores of MAX_WIDTH x 24 bits are read when a pixel is taken and written when
// it leaves the first stage; the 3x3 window is a row of column cells that shift
// once per pixel. Line stores come up uninitialized and need no clearing. Size
// writes take effect on the next pixel; kernel writes also on pixels in stage 1.
module rgb_sharpen_convolution_3x3
  import rsc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  chan_t                  red_in,
  input  chan_t                  green_in,
  input  chan_t                  blue_in,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [OUT_COL_W-1:0]   out_column,
  output logic [OUT_ROW_W-1:0]   out_row,
  output chan_t                  red_out,
  output chan_t                  green_out,
  output chan_t                  blue_out,
  output logic                   last_of_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [KSEL_W-1:0] kernel_sel;
  logic [FW_W-1:0]   w_m1, fw, wc;
  logic [FH_W-1:0]   h_m1, fh, hc;

  always_comb begin
    fw = cfg_data[FW_W-1:0];
    fh = cfg_data[FH_W-1:0];
    if (fw < FW_W'(DIM_MIN)) begin
      wc = FW_W'(DIM_MIN);
    end else if (32'(fw) > MAX_WIDTH) begin
      wc = FW_W'(MAX_WIDTH);
    end else begin
      wc = fw;
    end
    if (fh < FH_W'(DIM_MIN)) begin
      hc = FH_W'(DIM_MIN);
    end else if (32'(fh) > MAX_HEIGHT) begin
      hc = FH_W'(MAX_HEIGHT);
    end else begin
      hc = fh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_sel <= '0;
      w_m1       <= FW_W'(RESET_WIDTH - 1);
      h_m1       <= FH_W'(RESET_HEIGHT - 1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KERNEL_SELECT: kernel_sel <= cfg_data[KSEL_W-1:0];
        CFG_FRAME_WIDTH:   w_m1       <= wc - FW_W'(1);
        CFG_FRAME_HEIGHT:  h_m1       <= hc - FH_W'(1);
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1, v2, v3, phase3;
  logic has_int3, has_bord3;
  logic last_sel, s3_done, s3_load, s2_load, s1_load, accept, s1_leave;

  assign last_sel    = !(has_int3 && has_bord3 && !phase3);
  assign s3_done     = v3 && !result_stall && last_sel;
  assign s3_load     = !v3 || s3_done;
  assign s2_load     = !v2 || s3_load;
  assign s1_load     = !v1 || s2_load;
  assign pixel_stall = !s1_load;
  assign accept      = pixel_valid && s1_load;
  assign s1_leave    = v1 && s2_load;

  // raster position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          int_a, bord_a, wrap_a, row_end_a;

  always_comb begin
    wrap_a    = 32'(col) >= 32'(w_m1);
    row_end_a = 32'(row) >= 32'(h_m1);
    int_a     = (col >= CW'(2)) && (row >= RW'(2)) &&
                (32'(col) <= 32'(w_m1)) && (32'(row) <= 32'(h_m1));
    bord_a    = (col == '0) || (row == '0) || wrap_a || row_end_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (wrap_a) begin
        col <= '0;
        row <= row_end_a ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // stage 1: pixel with line-store read data
  pixel_t        px1;
  logic [CW-1:0] c1;
  logic [RW-1:0] r1;
  logic          int1, bord1, row_nz1;
  pixel_t        older_rd, newer_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      px1     <= {blue_in, green_in, red_in};
      c1      <= col;
      r1      <= row;
      int1    <= int_a;
      bord1   <= bord_a;
      row_nz1 <= (row != '0);
    end
  end

  rsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_line (
    .clk     (clk),
    .wr_en   (s1_leave && row_nz1),
    .wr_addr (c1),
    .wr_data (newer_rd),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (older_rd)
  );

  rsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_line (
    .clk     (clk),
    .wr_en   (s1_leave),
    .wr_addr (c1),
    .wr_data (px1),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (newer_rd)
  );

  // window cells: current column -> middle cell -> left cell
  column_t   cur_col, mid_col, left_col;
  psum_vec_t mid_psum, left_psum;

  assign cur_col = {px1, newer_rd, older_rd};

  rsc_column_cell u_mid_cell (
    .clk     (clk),
    .shift   (s1_leave),
    .col_in  (cur_col),
    .weights (kernel_column(kernel_sel, 1)),
    .col_out (mid_col),
    .psum    (mid_psum)
  );

  rsc_column_cell u_left_cell (
    .clk     (clk),
    .shift   (s1_leave),
    .col_in  (mid_col),
    .weights (kernel_column(kernel_sel, 0)),
    .col_out (left_col),
    .psum    (left_psum)
  );

  // stage 2: column partial sums
  psum_vec_t     pl2, pm2, pr2;
  pixel_t        px2;
  logic [CW-1:0] c2;
  logic [RW-1:0] r2;
  logic          int2, bord2;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      pl2   <= left_psum;
      pm2   <= mid_psum;
      pr2   <= col_sum(kernel_column(kernel_sel, 2), cur_col);
      px2   <= px1;
      c2    <= c1;
      r2    <= r1;
      int2  <= int1;
      bord2 <= bord1;
    end
  end

  // total and clamp
  pixel_t filt;
  psum_t  tot;

  always_comb begin
    filt = '0;
    tot  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tot = pl2[ch] + pm2[ch] + pr2[ch];
      if (tot < 0) begin
        filt[ch] = '0;
      end else if (tot > CLAMP_HI) begin
        filt[ch] = CLAMP_HI[CHAN_W-1:0];
      end else begin
        filt[ch] = tot[CHAN_W-1:0];
      end
    end
  end

  // stage 3: result pair
  pixel_t        filt3, px3;
  logic [CW-1:0] c3;
  logic [RW-1:0] r3;

  always_ff @(posedge clk) begin
    if (s3_load) begin
      filt3     <= filt;
      px3       <= px2;
      c3        <= c2;
      r3        <= r2;
      has_int3  <= int2;
      has_bord3 <= bord2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      phase3 <= 1'b0;
    end else begin
      if (s1_load) begin
        v1 <= pixel_valid;
      end
      if (s2_load) begin
        v2 <= v1;
      end
      if (s3_load) begin
        v3     <= v2 && (int2 || bord2);
        phase3 <= 1'b0;
      end else if (!result_stall) begin
        phase3 <= 1'b1;
      end
    end
  end

  // result port
  logic cur_int;

  assign cur_int      = has_int3 && !phase3;
  assign result_valid = v3;
  assign last_of_item = last_sel;
  assign out_column   = cur_int ? OUT_COL_W'(c3 - CW'(1)) : OUT_COL_W'(c3);
  assign out_row      = cur_int ? OUT_ROW_W'(r3 - RW'(1)) : OUT_ROW_W'(r3);
  assign red_out      = cur_int ? filt3[0] : px3[0];
  assign green_out    = cur_int ? filt3[1] : px3[1];
  assign blue_out     = cur_int ? filt3[2] : px3[2];

endmodule

### bench/tb_rgb_sharpen_convolution_3x3.sv
// Self-checking bench for rgb_sharpen_convolution_3x3: random raster frames, all kernels,
// saturated and mid-frame frame sizes, checked against a built-in sharpen predictor.
// Depends on rsc_pkg and the rgb_sharpen_convolution_3x3 RTL only.
module tb_rgb_sharpen_convolution_3x3;
  import rsc_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int RANDOM_PIXELS = 1070;
  localparam int REPORT_CAP    = 40;

  localparam logic [KSEL_W-1:0] KSEL_CROSS  = 2'd0;
  localparam logic [KSEL_W-1:0] KSEL_FULL   = 2'd1;
  localparam logic [KSEL_W-1:0] KSEL_ALT    = 2'd2;
  localparam logic [KSEL_W-1:0] KSEL_UNUSED = 2'd3;

  // row-major 3x3 taps: cross, full, alternate
  localparam int SHARPEN_TAPS [3][9] = '{
    '{ 0, -1,  0, -1, 5, -1,  0, -1,  0},
    '{-1, -1, -1, -1, 9, -1, -1, -1, -1},
    '{ 1, -2,  1, -2, 5, -2,  1, -2,  1}
  };

  typedef struct packed {
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] row;
    chan_t                red;
    chan_t                green;
    chan_t                blue;
    logic                 last;
  } sharpened_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  cfg_index_t           cfg_index = CFG_KERNEL_SELECT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  chan_t                red_in = '0;
  chan_t                green_in = '0;
  chan_t                blue_in = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [OUT_COL_W-1:0] out_column;
  logic [OUT_ROW_W-1:0] out_row;
  chan_t                red_out;
  chan_t                green_out;
  chan_t                blue_out;
  logic                 last_of_item;

  rgb_sharpen_convolution_3x3 dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_column   (out_column),
    .out_row      (out_row),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_of_item (last_of_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [KSEL_W-1:0] kernel_reg = KSEL_CROSS;
  logic [FW_W-1:0]   width_reg = FW_W'(RESET_WIDTH);
  logic [FH_W-1:0]   height_reg = FH_W'(RESET_HEIGHT);
  bit [PIX_W-1:0]    older_line [MAX_W];
  bit [PIX_W-1:0]    newer_line [MAX_W];
  bit [PIX_W-1:0]    prev2_col [3];
  bit [PIX_W-1:0]    prev1_col [3];
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;

  sharpened_t        expected_pixels [$];
  bit [PIX_W-1:0]    pending_pixels [$];

  int errors = 0;
  int pixels_in = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int holds_asked = 0;
  int holds_granted = 0;

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_sharpen(input bit [PIX_W-1:0] px);
    int unsigned    w, h, c, r, sel, i, ch, k;
    int             acc;
    bit [PIX_W-1:0] cur [3];
    bit [PIX_W-1:0] win [9];
    bit [PIX_W-1:0] res;
    bit             inner, border;
    sharpened_t     item;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    c = col_pos;
    r = row_pos;
    sel = (kernel_reg == KSEL_UNUSED) ? KSEL_CROSS : kernel_reg;
    cur[0] = '0;
    cur[1] = '0;
    cur[2] = px;
    if (c < MAX_W) begin
      if (r >= 1) begin
        cur[0] = older_line[c];
        cur[1] = newer_line[c];
        older_line[c] = cur[1];
      end
      newer_line[c] = px;
    end
    inner = (c >= 2) && (r >= 2) && (c < w) && (r < h);
    border = (c == 0) || (r == 0) || (c >= w - 1) || (r >= h - 1);
    if (inner) begin
      for (i = 0; i < 3; i++) begin
        win[i * 3]     = prev2_col[i];
        win[i * 3 + 1] = prev1_col[i];
        win[i * 3 + 2] = cur[i];
      end
      for (ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (k = 0; k < 9; k++) acc += SHARPEN_TAPS[sel][k] * int'(win[k][8 * ch +: 8]);
        res[8 * ch +: 8] = (acc > 255) ? 8'd255 : (acc < 0) ? 8'd0 : 8'(acc);
      end
      item.column = OUT_COL_W'(c - 1);
      item.row    = OUT_ROW_W'(r - 1);
      item.red    = res[7:0];
      item.green  = res[15:8];
      item.blue   = res[23:16];
      item.last   = !border;
      expected_pixels.push_back(item);
    end
    for (i = 0; i < 3; i++) begin
      prev2_col[i] = prev1_col[i];
      prev1_col[i] = cur[i];
    end
    if (border) begin
      item.column = OUT_COL_W'(c);
      item.row    = OUT_ROW_W'(r);
      item.red    = px[7:0];
      item.green  = px[15:8];
      item.blue   = px[23:16];
      item.last   = 1'b1;
      expected_pixels.push_back(item);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // pixel driver: bursts and gaps, fed from pending_pixels
  int burst_left = 0;
  int gap_left = 0;
  bit [PIX_W-1:0] next_px;

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        predict_sharpen({blue_in, green_in, red_in});
        pixels_in++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          next_px = pending_pixels.pop_front();
          pixel_valid <= 1'b1;
          red_in      <= next_px[7:0];
          green_in    <= next_px[15:8];
          blue_in     <= next_px[23:16];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // result stall: random modes, plus long holds on request
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (holds_granted != holds_asked) begin
      holds_granted++;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default:     result_stall <= (mode_left % 4 == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  sharpened_t want_px;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, got column %0d row %0d",
                   $time, out_column, out_row);
      end else begin
        want_px = expected_pixels.pop_front();
        check_field("out_column", want_px.column, out_column);
        check_field("out_row", want_px.row, out_row);
        check_field("red_out", want_px.red, red_out);
        check_field("green_out", want_px.green, green_out);
        check_field("blue_out", want_px.blue, blue_out);
        check_field("last_of_item", want_px.last, last_of_item);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic chan_t random_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return chan_t'($urandom);
    endcase
  endfunction

  task automatic push_random(input int n);
    repeat (n) pending_pixels.push_back({random_chan(), random_chan(), random_chan()});
  endtask

  // 3x3 frame, center opposite to its neighbors so both clamp limits are hit
  task automatic push_spike_frame(input bit bright_center);
    chan_t hi, lo;
    int    i;
    hi = bright_center ? 8'hFF : 8'h00;
    lo = ~hi;
    for (i = 0; i < 9; i++) begin
      if (i == 4) pending_pixels.push_back({random_chan(), lo, hi});
      else pending_pixels.push_back({random_chan(), hi, lo});
    end
  endtask

  // wait until the block is drained, then let the pipeline go quiet
  task automatic settle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || pixel_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      CFG_KERNEL_SELECT: kernel_reg = KSEL_W'(value);
      CFG_FRAME_WIDTH:   width_reg = FW_W'(value);
      default:           height_reg = FH_W'(value);
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  int random_count;
  int round;
  int frames;
  int frame_pixels;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes, then width shrinks under the column counter mid-row
    push_random(5);
    settle();
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    push_random(7);
    settle();

    // undersized dimensions saturate to 3
    write_reg(CFG_KERNEL_SELECT, KSEL_FULL);
    write_reg(CFG_FRAME_WIDTH, 2);
    write_reg(CFG_FRAME_HEIGHT, 0);
    push_spike_frame(1'b1);
    settle();
    write_reg(CFG_KERNEL_SELECT, KSEL_ALT);
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 1);
    push_spike_frame(1'b0);
    settle();

    // oversized height, then height shrinks below the row counter
    write_reg(CFG_KERNEL_SELECT, KSEL_UNUSED);
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 8191);
    push_random(12);
    settle();
    write_reg(CFG_FRAME_HEIGHT, 3);
    push_random(12);
    settle();

    // oversized width, then width shrinks under the column counter
    write_reg(CFG_FRAME_WIDTH, 4095);
    push_random(16);
    settle();
    write_reg(CFG_FRAME_WIDTH, 4);
    push_random(9);
    settle();

    random_count = 0;
    round = 0;
    while (random_count < RANDOM_PIXELS) begin
      if (round == 0) begin
        write_reg(CFG_KERNEL_SELECT, $urandom_range(0, 3));
        write_reg(CFG_FRAME_WIDTH, 40);
        write_reg(CFG_FRAME_HEIGHT, 6);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(CFG_KERNEL_SELECT, $urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
          write_reg(CFG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
                                     ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) :
                                     $urandom_range(3, 12));
        if ($urandom_range(0, 3) != 0)
          write_reg(CFG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
                                      $urandom_range(3, 8));
      end
      if (round == 0 || round == 8) holds_asked++;
      frame_pixels = eff_dim(width_reg, MAX_W) * eff_dim(height_reg, MAX_H);
      frames = $urandom_range(1, 3);
      push_random(frames * frame_pixels);
      random_count += frames * frame_pixels;
      round++;
      settle();
    end

    $display("Sharpen run: %0d pixel transactions, %0d results checked, %0d register writes.",
             pixels_in, results_seen, reg_writes);
    $display("Covered all kernel codes, saturated and mid-frame sizes, stalls and long holds.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
